### hw/rtl/mkss_pkg.sv
package mkss_pkg;

  // Default table size and fixed field widths
  localparam int SLOTS_DEF = 16;
  localparam int KEY_W     = 16;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SELECT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Control from the sequencer to the shared key comparator
  typedef struct packed {
    logic clr;  // start of a select scan
    logic act;  // key read data of this cycle belongs to the scan
    logic vld;  // slot of that key holds a message
  } cmp_ctl_t;

endpackage

### hw/rtl/max_key_slot_store_top.sv
// Slot table of SLOTS messages, each kept as a valid mark and a 16-bit half-float
// key; the payload sits in outside memory at the slot index. Pulse start with
// cmd_i while busy is low: insert takes the lowest free slot, select finds the
// valid non-NaN key of greatest magnitude (highest slot wins a tie), remove
// clears one slot, flush clears all. Exactly one result beat follows each
// command, flagged by done_o for a single cycle; the receiver cannot stall it,
// so capture status_o, result_slot_o and entry_count_o on that cycle. A select
// walks one slot pointer through the key RAM's single read port into one
// magnitude comparator, one slot per cycle; an insert walks the same pointer
// over the valid marks up to the lowest free slot. Remove, flush, an insert on
// a full table and a select on an empty one skip the walk. busy is high from
// the accepting edge until done_o rises.
module max_key_slot_store_top import mkss_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [KEY_W-1:0]  key_bits_i,
  input  logic [IDX_W-1:0]  slot_index_i,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o,
  output logic [IDX_W-1:0]  result_slot_o,
  output logic [CNT_W-1:0]  entry_count_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_DRN  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_EXEC = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [IW-1:0]     ptr_q, ptr_d;
  logic [SLOTS-1:0]  valid_q, valid_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              rd_act_q, rd_act_d;
  logic [IW-1:0]     rd_ptr_q, rd_ptr_d;
  logic              done_q, done_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [IDX_W-1:0]  rslot_q, rslot_d;
  logic [CNT_W-1:0]  ecount_q, ecount_d;

  logic              accept;
  logic              full;
  logic              idx_ok;
  logic              ram_we;
  logic [KEY_W-1:0]  ram_rdata;
  cmp_ctl_t          cmp_ctl;
  logic              cmp_found;
  logic [IW-1:0]     cmp_slot;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign full   = (count_q == CW'(SLOTS));
  assign idx_ok = (32'(idx_q) < SLOTS);

  // Key store, one slot read per cycle during a select scan
  mkss_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (key_q),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // Shared magnitude comparator, fed one slot a beat
  assign cmp_ctl.clr = accept && (cmd_i == CMD_SELECT);
  assign cmp_ctl.act = rd_act_q;
  assign cmp_ctl.vld = valid_q[rd_ptr_q];

  mkss_cmp #(
    .SLOTS (SLOTS)
  ) u_cmp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (cmp_ctl),
    .key_i       (ram_rdata),
    .slot_i      (rd_ptr_q),
    .found_o     (cmp_found),
    .best_slot_o (cmp_slot)
  );

  // Sequencer
  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    valid_d  = valid_q;
    count_d  = count_q;
    cmd_d    = cmd_q;
    key_d    = key_q;
    idx_d    = idx_q;
    rd_act_d = 1'b0;
    rd_ptr_d = ptr_q;
    done_d   = 1'b0;
    status_d = status_q;
    rslot_d  = rslot_q;
    ecount_d = ecount_q;
    ram_we   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d = cmd_i;
          key_d = key_bits_i;
          idx_d = slot_index_i;
          ptr_d = '0;
          if (cmd_i == CMD_INSERT && !full) begin
            state_d = S_INS;
          end else if (cmd_i == CMD_SELECT && count_q != '0) begin
            state_d = S_SEL;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_INS: begin
        // a free slot is certain, the table was not full
        if (!valid_q[ptr_q]) begin
          ram_we          = 1'b1;
          valid_d[ptr_q]  = 1'b1;
          count_d         = count_q + CW'(1);
          done_d          = 1'b1;
          status_d        = ST_OK;
          rslot_d         = IDX_W'(ptr_q);
          ecount_d        = CNT_W'(count_d);
          state_d         = S_IDLE;
        end else begin
          ptr_d = ptr_q + IW'(1);
        end
      end
      S_SEL: begin
        rd_act_d = 1'b1;
        if (ptr_q == IW'(SLOTS - 1)) begin
          state_d = S_DRN;
        end else begin
          ptr_d = ptr_q + IW'(1);
        end
      end
      S_DRN: begin
        // last key beat is compared at this edge
        state_d = S_FIN;
      end
      S_FIN: begin
        done_d   = 1'b1;
        status_d = cmp_found ? ST_OK : ST_EMPTY;
        rslot_d  = cmp_found ? IDX_W'(cmp_slot) : '0;
        ecount_d = CNT_W'(count_q);
        state_d  = S_IDLE;
      end
      S_EXEC: begin
        done_d  = 1'b1;
        rslot_d = '0;
        state_d = S_IDLE;
        case (cmd_q)
          CMD_INSERT: status_d = ST_FULL;
          CMD_SELECT: status_d = ST_EMPTY;
          CMD_REMOVE: begin
            if (idx_ok && valid_q[IW'(idx_q)]) begin
              valid_d[IW'(idx_q)] = 1'b0;
              count_d             = count_q - CW'(1);
              status_d            = ST_OK;
            end else begin
              status_d = ST_EMPTY;
            end
          end
          default: begin
            valid_d  = '0;
            count_d  = '0;
            status_d = ST_OK;
          end
        endcase
        ecount_d = CNT_W'(count_d);
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      count_q  <= '0;
      rd_act_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      count_q  <= count_d;
      rd_act_q <= rd_act_d;
      done_q   <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    idx_q    <= idx_d;
    rd_ptr_q <= rd_ptr_d;
    status_q <= status_d;
    rslot_q  <= rslot_d;
    ecount_q <= ecount_d;
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign result_slot_o = rslot_q;
  assign entry_count_o = ecount_q;

  // Count tracks the valid marks
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("entry count out of step with valid marks");

  // An accepted command gets busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("not busy after accept");

  // A result beat only closes a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy) && !busy))
    else $error("result beat without a command");

  // Full is only reported on a full table
  a_full_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ST_FULL) |-> full)
    else $error("full reported on a table with room");

endmodule

### hw/rtl/mkss_ram.sv
module mkss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/mkss_cmp.sv
module mkss_cmp import mkss_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  cmp_ctl_t                                 ctl_i,
  input  logic [KEY_W-1:0]                         key_i,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] slot_i,
  output logic                                     found_o,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] best_slot_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic          found_q, found_d;
  logic [14:0]   best_q, best_d;
  logic [IW-1:0] slot_q, slot_d;
  logic          key_nan;
  logic          take;

  // NaN: exponent all ones, mantissa nonzero
  assign key_nan = (key_i[14:10] == 5'h1f) && (key_i[9:0] != 10'd0);

  // >= so the later (higher) slot wins a tie
  assign take = ctl_i.act && ctl_i.vld && !key_nan
                && (!found_q || (key_i[14:0] >= best_q));

  always_comb begin
    found_d = found_q;
    best_d  = best_q;
    slot_d  = slot_q;
    if (ctl_i.clr) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d = 1'b1;
      best_d  = key_i[14:0];
      slot_d  = slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    slot_q <= slot_d;
  end

  assign found_o     = found_q;
  assign best_slot_o = slot_q;

  // A clear always leaves nothing found
  a_clr_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clr |=> !found_q)
    else $error("comparator not cleared");

  // A winning beat is never a NaN key
  a_no_nan_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> !((key_i[14:10] == 5'h1f) && (key_i[9:0] != 10'd0)))
    else $error("NaN key taken");

  // Once found, stays found until the next clear
  a_found_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && !ctl_i.clr) |=> found_q)
    else $error("found flag dropped");

endmodule
